@@ rtl/mrba_pkg.sv @@
package mrba_pkg;

  localparam int ADDR_BITS = 32;

  localparam logic [ADDR_BITS-1:0] USABLE_TYPE = 32'd1;

  localparam logic [0:0] OP_REGISTER = 1'b0;
  localparam logic [0:0] OP_ALLOCATE = 1'b1;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_SKIPPED = 3'd1;
  localparam logic [2:0] ST_CLOSED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_GRANTED = 3'd4;
  localparam logic [2:0] ST_NOFIT   = 3'd5;

  typedef struct packed {
    logic [0:0]           opcode;
    logic [ADDR_BITS-1:0] region_base;
    logic [ADDR_BITS-1:0] region_length;
    logic [ADDR_BITS-1:0] region_type;
    logic [30:0]          alloc_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] granted_address;
    logic [4:0]           regions_held;
  } out_item_t;

  // One region table entry: end address and bump pointer.
  typedef struct packed {
    logic [ADDR_BITS-1:0] limit_addr;
    logic [ADDR_BITS-1:0] next_free;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REG  = 4'b0010,
    S_ARD  = 4'b0100,
    S_ACHK = 4'b1000
  } state_t;

endpackage

@@ rtl/mrba_ram.sv @@
module mrba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/multi_region_bump_allocator_top.sv @@
// Multi-region bump-pointer allocator.
// Transactions enter on in_data and are accepted at a rising edge where start is
// high and busy is low. A register transaction (opcode 0) offers one memory-map
// entry; an allocate transaction (opcode 1) asks for alloc_size bytes from the
// regions held so far. Every transaction yields exactly one result on out_data,
// shown for a single cycle with out_valid high; the receiver cannot stall, so
// the result must be taken in that cycle.
// A register transaction shows its result from the register step. An
// allocation visits the held regions from the highest-numbered one downwards,
// with a RAM read and then a fit test on the shared 33-bit adder for each
// region, so it shows its result from the fit test of the first region that
// fits, or from the empty scan after the last one when none of the held
// regions fits. busy is high throughout and a new transaction may be accepted
// in the very cycle a result is shown.
// The region table lives in a small RAM with a registered read port; entries
// are only read below the region count, so it needs no clearing. Reset clears
// the region count, the map-closed flag, the sequencer and the result strobe.
module multi_region_bump_allocator_top
  import mrba_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // Sequencer and held state.
  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             closed_r, closed_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  // Region table RAM signals.
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  entry_t           ram_rd_data;

  // The one shared adder: base + length for map entries, pointer + size for
  // the fit test. It is 33 bits wide so the fit test sees the carry.
  logic [ADDR_BITS-1:0] add_a, add_b;
  logic [ADDR_BITS:0]   add_sum;
  logic                 fits;
  logic [CNT_W-1:0]     count_inc;
  logic [CNT_W-1:0]     scan_dec;

  assign add_a   = (state_r == S_REG) ? item_r.region_base : ram_rd_data.next_free;
  assign add_b   = (state_r == S_REG) ? item_r.region_length : {1'b0, item_r.alloc_size};
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign fits    = (add_sum <= {1'b0, ram_rd_data.limit_addr});

  assign count_inc = count_r + 1'b1;
  assign scan_dec  = scan_r - 1'b1;

  mrba_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_REGIONS)
  ) u_region_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    closed_nxt    = closed_r;
    scan_nxt      = scan_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = count_r[IDX_W-1:0];
    ram_wr_data   = '{limit_addr: add_sum[ADDR_BITS-1:0], next_free: item_r.region_base};
    ram_rd_en     = 1'b0;
    ram_rd_addr   = scan_dec[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          scan_nxt = count_r;
          state_nxt = (in_data.opcode == OP_ALLOCATE) ? S_ARD : S_REG;
        end
      end

      S_REG: begin
        // Map entry: a closed map ignores everything, a sum that wraps to
        // zero in its low 32 bits closes it, then type and table space are checked.
        out_valid_nxt           = 1'b1;
        out_nxt.granted_address = '0;
        out_nxt.regions_held    = 5'(count_r);
        if (closed_r) begin
          out_nxt.status = ST_CLOSED;
        end else if (add_sum[ADDR_BITS-1:0] == '0) begin
          closed_nxt     = 1'b1;
          out_nxt.status = ST_CLOSED;
        end else if (item_r.region_type != USABLE_TYPE) begin
          out_nxt.status = ST_SKIPPED;
        end else if (count_r == CNT_W'(MAX_REGIONS)) begin
          out_nxt.status = ST_FULL;
        end else begin
          ram_wr_en            = 1'b1;
          count_nxt            = count_inc;
          out_nxt.status       = ST_STORED;
          out_nxt.regions_held = 5'(count_inc);
        end
        state_nxt = S_IDLE;
      end

      S_ARD: begin
        if (scan_r == '0) begin
          // Every held region has been tried without success.
          out_valid_nxt           = 1'b1;
          out_nxt.status          = ST_NOFIT;
          out_nxt.granted_address = '0;
          out_nxt.regions_held    = 5'(count_r);
          state_nxt               = S_IDLE;
        end else begin
          ram_rd_en = 1'b1;
          scan_nxt  = scan_dec;
          state_nxt = S_ACHK;
        end
      end

      S_ACHK: begin
        if (fits) begin
          ram_wr_en               = 1'b1;
          ram_wr_addr             = scan_r[IDX_W-1:0];
          ram_wr_data             = '{limit_addr: ram_rd_data.limit_addr,
                                      next_free: add_sum[ADDR_BITS-1:0]};
          out_valid_nxt           = 1'b1;
          out_nxt.status          = ST_GRANTED;
          out_nxt.granted_address = ram_rd_data.next_free;
          out_nxt.regions_held    = 5'(count_r);
          state_nxt               = S_IDLE;
        end else begin
          state_nxt = S_ARD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    scan_r <= scan_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result strobe only ever follows a register step, a fit or an empty scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_REG || $past(state_r) == S_ACHK ||
                     $past(state_r) == S_ARD))
    else $error("result strobe without a finishing step");

  // The region count never passes the table size.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REGIONS))
    else $error("region count beyond table size");

  // Only a granted allocation carries an address.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_GRANTED) |-> (out_r.granted_address == '0))
    else $error("address reported without a grant");

  // An accepted transaction always makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start the sequencer");

endmodule
